@@ sv/mvwo_pkg.sv @@
package mvwo_pkg;

   // Item opcodes
   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_NOTE_ON   = 3'd1;
   localparam logic [2:0] OP_VOICE_OFF = 3'd2;
   localparam logic [2:0] OP_SAMPLE_WR = 3'd3;
   localparam logic [2:0] OP_DESC_WR   = 3'd4;

   // Result kinds and status codes
   localparam logic       KIND_SAMPLE = 1'b0;
   localparam logic       KIND_ACK    = 1'b1;
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_LOW      = 2'd1;
   localparam logic [1:0] ST_HIGH     = 2'd2;

   // Configuration register indexes
   localparam int         CSR_INDEX_BITS      = 8;
   localparam logic [7:0] CSR_WAVEFORM_SELECT = 8'd0;
   localparam logic [7:0] CSR_IDLE_LEVEL      = 8'd1;

   // Note decode
   localparam logic [6:0] LOWEST_NOTE      = 7'd24;
   localparam logic [3:0] NOTES_PER_OCTAVE = 4'd12;
   localparam logic [3:0] TOP_OCTAVE       = 4'd7;

   localparam int PHASE_BITS  = 11;
   localparam int LENGTH_BITS = 12;
   localparam int BASE_BITS   = 16;
   localparam int SAMPLE_BITS = 16;

   typedef struct packed {
      logic [BASE_BITS-1:0]   base;
      logic [LENGTH_BITS-1:0] length;
   } desc_type;

   typedef struct packed {
      logic note_load;
      logic voice_off;
      logic advance;
   } voice_ctl_type;

endpackage

@@ sv/mvwo_if.sv @@
interface mvwo_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [2:0]  voice;
   logic [6:0]  midi_note;
   logic [15:0] address;
   logic [15:0] sample_data;
   logic [1:0]  desc_waveform;
   logic [3:0]  desc_pitch_class;
   logic [11:0] desc_length;

   modport source (
      output valid, opcode, voice, midi_note, address, sample_data,
             desc_waveform, desc_pitch_class, desc_length,
      input  ready
   );
   modport sink (
      input  valid, opcode, voice, midi_note, address, sample_data,
             desc_waveform, desc_pitch_class, desc_length,
      output ready
   );
endinterface

interface mvwo_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  voice_index;
   logic [11:0] level;
   logic [1:0]  status;
   logic        last;

   modport source (
      output valid, kind, voice_index, level, status, last,
      input  ready
   );
   modport sink (
      input  valid, kind, voice_index, level, status, last,
      output ready
   );
endinterface

interface mvwo_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

@@ sv/mvwo_sample_mem.sv @@
module mvwo_sample_mem
   import mvwo_pkg::*;
#(
   parameter int SAMPLE_ADDR_BITS = 16
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [SAMPLE_ADDR_BITS-1:0] waddr,
   input  logic [SAMPLE_BITS-1:0]      wdata,
   input  logic                        re,
   input  logic [SAMPLE_ADDR_BITS-1:0] raddr,
   output logic [SAMPLE_BITS-1:0]      rdata
);

   logic [SAMPLE_BITS-1:0] mem_ff [2**SAMPLE_ADDR_BITS];
   logic [SAMPLE_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/mvwo_desc_mem.sv @@
module mvwo_desc_mem
   import mvwo_pkg::*;
#(
   parameter  int WAVEFORM_COUNT = 4,
   localparam int DESC_DEPTH     = WAVEFORM_COUNT * 12,
   localparam int DAW            = $clog2(DESC_DEPTH)
) (
   input  logic           clock,
   input  logic           we,
   input  logic [DAW-1:0] waddr,
   input  desc_type       wdata,
   input  logic           re,
   input  logic [DAW-1:0] raddr,
   output desc_type       rdata
);

   desc_type mem_ff [DESC_DEPTH];
   desc_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/mvwo_voice_bank.sv @@
module mvwo_voice_bank
   import mvwo_pkg::*;
#(
   parameter  int VOICE_COUNT      = 6,
   parameter  int SAMPLE_ADDR_BITS = 16,
   localparam int VW               = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  voice_ctl_type               ctl,
   input  logic [VW-1:0]               idx,
   input  logic [2:0]                  note_octave,
   input  desc_type                    note_desc,
   output logic                        enabled,
   output logic [SAMPLE_ADDR_BITS-1:0] sample_addr
);

   localparam int SW = (SAMPLE_ADDR_BITS > BASE_BITS) ? SAMPLE_ADDR_BITS : BASE_BITS;

   logic [PHASE_BITS-1:0]  phase_ff  [VOICE_COUNT];
   logic [PHASE_BITS-1:0]  phase_in  [VOICE_COUNT];
   logic [2:0]             octave_ff [VOICE_COUNT];
   logic [2:0]             octave_in [VOICE_COUNT];
   logic [BASE_BITS-1:0]   base_ff   [VOICE_COUNT];
   logic [BASE_BITS-1:0]   base_in   [VOICE_COUNT];
   logic [LENGTH_BITS-1:0] length_ff [VOICE_COUNT];
   logic [LENGTH_BITS-1:0] length_in [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] enabled_ff;
   logic [VOICE_COUNT-1:0] enabled_in;

   logic [LENGTH_BITS-1:0] step;
   logic [LENGTH_BITS-1:0] sum;
   logic [LENGTH_BITS-1:0] wrapped;
   logic [PHASE_BITS-1:0]  new_phase;
   logic [SW-1:0]          addr_sum;

   // Advance the selected voice by one step, wrapped once by its table length, plus its sample address
   always_comb begin
      step      = LENGTH_BITS'(1) << octave_ff[idx];
      sum       = {1'b0, phase_ff[idx]} + step;
      wrapped   = (sum >= length_ff[idx]) ? (sum - length_ff[idx]) : sum;
      new_phase = wrapped[PHASE_BITS-1:0];
      addr_sum  = SW'(base_ff[idx]) + SW'(new_phase);
   end

   assign enabled     = enabled_ff[idx];
   assign sample_addr = addr_sum[SAMPLE_ADDR_BITS-1:0];

   always_comb begin
      phase_in   = phase_ff;
      octave_in  = octave_ff;
      base_in    = base_ff;
      length_in  = length_ff;
      enabled_in = enabled_ff;
      if (ctl.note_load) begin
         phase_in[idx]   = '0;
         octave_in[idx]  = note_octave;
         base_in[idx]    = note_desc.base;
         length_in[idx]  = note_desc.length;
         enabled_in[idx] = 1'b1;
      end
      if (ctl.voice_off) begin
         enabled_in[idx] = 1'b0;
      end
      if (ctl.advance && enabled_ff[idx]) begin
         phase_in[idx] = new_phase;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff  <= phase_in;
      octave_ff <= octave_in;
      base_ff   <= base_in;
      length_ff <= length_in;
      if (reset) begin
         enabled_ff <= '0;
      end else begin
         enabled_ff <= enabled_in;
      end
   end

endmodule

@@ sv/multi_voice_wavetable_oscillator_core.sv @@
// Polyphonic wavetable oscillator bank.
//
// Channels: req_bus carries one item per transfer (tick, note on, voice
// disable, sample write, descriptor write); rsp_bus returns result items;
// csr_bus writes waveform_select (index 0) and idle_level (index 1) and is
// always ready. Write configuration only while no item is in flight.
// A tick returns VOICE_COUNT samples, one per cycle while the receiver takes
// them, through the sample memory read register and the output register; no
// further item is taken until its last sample is loaded. The pace is set by
// the single read port of the sample memory, which serves one voice per cycle.
// A note on reads its descriptor and acknowledges once the output register is
// free; other items acknowledge the cycle after. Opcodes 5 to 7 give no result.
// Reset clears the configuration to its defaults, disables all voices and
// empties the output register. Sample and descriptor memories keep no reset
// and must be loaded before notes are played.
// When the receiver stalls, the result waits in the output register; the
// tick sequencer holds its next sample in the memory read register and
// resumes as soon as the output register frees up.
module multi_voice_wavetable_oscillator_core
   import mvwo_pkg::*;
#(
   parameter int VOICE_COUNT      = 6,
   parameter int WAVEFORM_COUNT   = 4,
   parameter int SAMPLE_ADDR_BITS = 16,
   parameter int MAX_TABLE_LEN    = 2048
) (
   input logic        clock,
   input logic        reset,
   mvwo_req_if.sink   req_bus,
   mvwo_rsp_if.source rsp_bus,
   mvwo_csr_if.sink   csr_bus
);

   localparam int VW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int CW  = $clog2(VOICE_COUNT + 1);
   localparam int DAW = $clog2(WAVEFORM_COUNT * 12);
   localparam int SW  = (SAMPLE_ADDR_BITS > BASE_BITS) ? SAMPLE_ADDR_BITS : BASE_BITS;

   localparam logic [CW-1:0] ISSUE_END   = CW'(VOICE_COUNT);
   localparam logic [VW-1:0] LAST_VOICE  = VW'(VOICE_COUNT - 1);
   localparam logic [4:0]    VOICE_LIMIT = 5'(VOICE_COUNT);
   localparam logic [4:0]    WAVE_LIMIT  = 5'(WAVEFORM_COUNT);
   localparam logic [3:0]    WAVE_TOP    = 4'(WAVEFORM_COUNT - 1);
   localparam logic [16:0]   MAX_LEN     = 17'(MAX_TABLE_LEN);
   // floor(x / 12) = (x * 171) >> 11 for every 7-bit x
   localparam logic [7:0]    RECIP_12    = 8'd171;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_NOTE = 2'd1;
   localparam logic [1:0] S_TICK = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  waveform_select_ff;
   logic [15:0] idle_level_ff;

   // Output register
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [2:0]  out_voice_ff, out_voice_in;
   logic [11:0] out_level_ff, out_level_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic        out_last_ff, out_last_in;

   // Pending note on
   logic [2:0]  note_voice_ff, note_voice_in;
   logic [1:0]  note_status_ff, note_status_in;
   logic [2:0]  note_octave_ff, note_octave_in;
   logic        note_apply_ff, note_apply_in;

   // Tick sequencer
   logic [CW-1:0] issue_cnt_ff, issue_cnt_in;
   logic          pend_ff, pend_in;
   logic          pend_en_ff, pend_en_in;
   logic [VW-1:0] pend_voice_ff, pend_voice_in;
   logic          pend_last_ff, pend_last_in;

   logic          can_load;
   logic          req_ready;
   logic          req_fire;
   logic          issue_go;
   logic          tick_load;
   logic [VW-1:0] issue_idx;

   // Note decode
   logic [6:0]  rel_note;
   logic [14:0] rel_prod;
   logic [3:0]  octave;
   logic [6:0]  class_wide;
   logic [3:0]  pitch_class;
   logic        note_low;
   logic        note_high;
   logic        voice_in_range;
   logic [3:0]  wave_sat;
   logic [7:0]  note_desc_idx;
   logic [7:0]  wr_desc_idx;
   logic        desc_wr_ok;
   logic [SW-1:0] wr_addr_ext;

   // Memory and voice bank controls
   logic                        sample_we;
   logic                        sample_re;
   logic [SAMPLE_ADDR_BITS-1:0] sample_raddr;
   logic [SAMPLE_BITS-1:0]      sample_rdata;
   logic                        desc_we;
   logic                        desc_re;
   desc_type                    desc_wdata;
   desc_type                    desc_rdata;
   voice_ctl_type               vctl;
   logic [VW-1:0]               bank_idx;
   logic                        bank_enabled;

   assign can_load  = !out_valid_ff || rsp_bus.ready;
   assign req_ready = (state_ff == S_IDLE) && can_load;
   assign req_fire  = req_bus.valid && req_ready;
   assign issue_idx = issue_cnt_ff[VW-1:0];
   assign issue_go  = (state_ff == S_TICK) && (issue_cnt_ff != ISSUE_END)
                      && (!pend_ff || can_load);
   assign tick_load = (state_ff == S_TICK) && pend_ff && can_load;

   // Split the note into octave and pitch class; check ranges, form descriptor fields
   always_comb begin
      rel_note       = req_bus.midi_note - LOWEST_NOTE;
      rel_prod       = 15'(rel_note) * 15'(RECIP_12);
      octave         = rel_prod[14:11];
      class_wide     = rel_note - (7'(octave) * 7'(NOTES_PER_OCTAVE));
      pitch_class    = class_wide[3:0];
      note_low       = req_bus.midi_note < LOWEST_NOTE;
      note_high      = !note_low && (octave > TOP_OCTAVE);
      voice_in_range = {2'b00, req_bus.voice} < VOICE_LIMIT;
      wave_sat       = ({3'b000, waveform_select_ff} >= WAVE_LIMIT)
                       ? WAVE_TOP : {2'b00, waveform_select_ff};
      note_desc_idx  = 8'(wave_sat) * 8'd12 + 8'(pitch_class);
      wr_desc_idx    = 8'(req_bus.desc_waveform) * 8'd12 + 8'(req_bus.desc_pitch_class);
      desc_wr_ok     = ({3'b000, req_bus.desc_waveform} < WAVE_LIMIT)
                       && (req_bus.desc_pitch_class < NOTES_PER_OCTAVE);
      desc_wdata.base   = req_bus.address;
      desc_wdata.length = (17'(req_bus.desc_length) > MAX_LEN)
                          ? LENGTH_BITS'(MAX_TABLE_LEN) : req_bus.desc_length;
      wr_addr_ext    = SW'(req_bus.address);
   end

   always_comb begin
      state_in       = state_ff;
      out_kind_in    = out_kind_ff;
      out_voice_in   = out_voice_ff;
      out_level_in   = out_level_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      note_voice_in  = note_voice_ff;
      note_status_in = note_status_ff;
      note_octave_in = note_octave_ff;
      note_apply_in  = note_apply_ff;
      issue_cnt_in   = issue_cnt_ff;
      pend_in        = pend_ff;
      pend_en_in     = pend_en_ff;
      pend_voice_in  = pend_voice_ff;
      pend_last_in   = pend_last_ff;
      sample_we      = 1'b0;
      sample_re      = 1'b0;
      desc_we        = 1'b0;
      desc_re        = 1'b0;
      vctl           = '0;
      bank_idx       = issue_idx;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.opcode) inside
                  OP_TICK: begin
                     issue_cnt_in = '0;
                     state_in     = S_TICK;
                  end
                  OP_NOTE_ON: begin
                     desc_re        = 1'b1;
                     note_voice_in  = req_bus.voice;
                     note_octave_in = octave[2:0];
                     note_status_in = note_low ? ST_LOW : (note_high ? ST_HIGH : ST_OK);
                     note_apply_in  = !note_low && !note_high && voice_in_range;
                     state_in       = S_NOTE;
                  end
                  OP_VOICE_OFF: begin
                     vctl.voice_off = voice_in_range;
                     bank_idx       = VW'(req_bus.voice);
                     out_valid_in   = 1'b1;
                     out_kind_in    = KIND_ACK;
                     out_voice_in   = req_bus.voice;
                     out_level_in   = '0;
                     out_status_in  = ST_OK;
                     out_last_in    = 1'b1;
                  end
                  OP_SAMPLE_WR, OP_DESC_WR: begin
                     sample_we     = req_bus.opcode == OP_SAMPLE_WR;
                     desc_we       = (req_bus.opcode == OP_DESC_WR) && desc_wr_ok;
                     out_valid_in  = 1'b1;
                     out_kind_in   = KIND_ACK;
                     out_voice_in  = '0;
                     out_level_in  = '0;
                     out_status_in = ST_OK;
                     out_last_in   = 1'b1;
                  end
                  default: begin
                     // unknown opcode: drop without a result
                  end
               endcase
            end
         end
         S_NOTE: begin
            // descriptor read data is ready; once the output is free, apply the note and acknowledge
            bank_idx = VW'(note_voice_ff);
            if (can_load) begin
               vctl.note_load = note_apply_ff;
               out_valid_in   = 1'b1;
               out_kind_in    = KIND_ACK;
               out_voice_in   = note_voice_ff;
               out_level_in   = '0;
               out_status_in  = note_status_ff;
               out_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_TICK: begin
            // issue one voice per cycle unless the output stalls; its sample returns next cycle
            if (issue_go) begin
               vctl.advance  = 1'b1;
               sample_re     = 1'b1;
               issue_cnt_in  = issue_cnt_ff + CW'(1);
               pend_in       = 1'b1;
               pend_en_in    = bank_enabled;
               pend_voice_in = issue_idx;
               pend_last_in  = issue_idx == LAST_VOICE;
            end else if (tick_load) begin
               pend_in = 1'b0;
            end
            if (tick_load) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_SAMPLE;
               out_voice_in  = 3'(pend_voice_ff);
               out_level_in  = pend_en_ff ? sample_rdata[15:4] : idle_level_ff[15:4];
               out_status_in = ST_OK;
               out_last_in   = pend_last_ff;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      out_kind_in_hold: begin
         out_kind_ff    <= out_kind_in;
         out_voice_ff   <= out_voice_in;
         out_level_ff   <= out_level_in;
         out_status_ff  <= out_status_in;
         out_last_ff    <= out_last_in;
         note_voice_ff  <= note_voice_in;
         note_status_ff <= note_status_in;
         note_octave_ff <= note_octave_in;
         note_apply_ff  <= note_apply_in;
         issue_cnt_ff   <= issue_cnt_in;
         pend_en_ff     <= pend_en_in;
         pend_voice_ff  <= pend_voice_in;
         pend_last_ff   <= pend_last_in;
      end
      if (reset) begin
         state_ff           <= S_IDLE;
         out_valid_ff       <= 1'b0;
         pend_ff            <= 1'b0;
         waveform_select_ff <= '0;
         idle_level_ff      <= 16'd32768;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_WAVEFORM_SELECT: waveform_select_ff <= csr_bus.data[1:0];
               CSR_IDLE_LEVEL:      idle_level_ff      <= csr_bus.data;
               default: begin
               end
            endcase
         end
      end
   end

   assign req_bus.ready       = req_ready;
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.kind        = out_kind_ff;
   assign rsp_bus.voice_index = out_voice_ff;
   assign rsp_bus.level       = out_level_ff;
   assign rsp_bus.status      = out_status_ff;
   assign rsp_bus.last        = out_last_ff;

   mvwo_sample_mem #(
      .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
   ) u_sample_mem (
      .clock (clock),
      .we    (sample_we),
      .waddr (wr_addr_ext[SAMPLE_ADDR_BITS-1:0]),
      .wdata (req_bus.sample_data),
      .re    (sample_re),
      .raddr (sample_raddr),
      .rdata (sample_rdata)
   );

   mvwo_desc_mem #(
      .WAVEFORM_COUNT (WAVEFORM_COUNT)
   ) u_desc_mem (
      .clock (clock),
      .we    (desc_we),
      .waddr (wr_desc_idx[DAW-1:0]),
      .wdata (desc_wdata),
      .re    (desc_re),
      .raddr (note_desc_idx[DAW-1:0]),
      .rdata (desc_rdata)
   );

   mvwo_voice_bank #(
      .VOICE_COUNT      (VOICE_COUNT),
      .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
   ) u_voice_bank (
      .clock       (clock),
      .reset       (reset),
      .ctl         (vctl),
      .idx         (bank_idx),
      .note_octave (note_octave_ff),
      .note_desc   (desc_rdata),
      .enabled     (bank_enabled),
      .sample_addr (sample_raddr)
   );

`ifndef SYNTHESIS
   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_ACK) |-> out_last_ff)
      else $error("acknowledgment without last");
   a_last_sample_voice: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_SAMPLE && out_last_ff)
         |-> (out_voice_ff == 3'(VOICE_COUNT - 1)))
      else $error("last sample of a tick not on the final voice");
   a_pend_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_TICK))
      else $error("pending sample outside a tick");
   a_tick_continues: assert property (@(posedge clock) disable iff (reset)
      (tick_load && !pend_last_ff) |=> (state_ff == S_TICK))
      else $error("tick ended before its final voice");
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !pend_ff && state_ff == S_IDLE))
      else $error("reset left the block busy");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import mvwo_pkg::*;

   localparam int VOICES    = 6;
   localparam int WAVES     = 4;
   localparam int TABLE_MAX = 2048;
   // Two copies of the oscillator state: one tracks what has been queued so
   // far (so stimulus never reads memory that was never loaded), the other
   // follows the items the block has actually taken.
   localparam int PLAN = 0;
   localparam int LIVE = 1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  voice;
      logic [6:0]  midi_note;
      logic [15:0] address;
      logic [15:0] sample_data;
      logic [1:0]  desc_waveform;
      logic [3:0]  desc_pitch_class;
      logic [11:0] desc_length;
   } osc_item_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  voice_index;
      logic [11:0] level;
      logic [1:0]  status;
      logic        last;
   } osc_result_type;

   logic clock;
   logic reset;

   mvwo_req_if req_bus ();
   mvwo_rsp_if rsp_bus ();
   mvwo_csr_if csr_bus ();

   multi_voice_wavetable_oscillator_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Oscillator state, per copy
   logic [10:0] phase_acc  [2][VOICES];
   logic [2:0]  octave_of  [2][VOICES];
   logic [15:0] table_base [2][VOICES];
   logic [11:0] table_len  [2][VOICES];
   logic        voice_live [2][VOICES];
   logic [15:0] wave_mem   [2][65536];
   desc_type    desc_mem   [2][WAVES*12];
   logic [1:0]  sel_wave   [2];
   logic [15:0] idle_raw   [2];

   // Which sample words and descriptors the queued stimulus has loaded
   bit          mem_loaded  [65536];
   bit          desc_loaded [WAVES*12];

   osc_item_type   queued_items[$];
   osc_result_type due_results[$];
   osc_item_type   on_bus;
   int             items_made;
   int             mismatch_count;

   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_req;
   bit          hold_done;
   int          hold_left;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Waveform set that a new note takes; clamp to the last set.
   function automatic int active_wave(int c);
      return (sel_wave[c] >= WAVES) ? WAVES - 1 : int'(sel_wave[c]);
   endfunction

   // Phase after one tick: add the step, wrap once by the table length
   // (a zero length never wraps), keep 11 bits.
   function automatic logic [10:0] stepped_phase(int c, int v);
      int sum;
      sum = int'(phase_acc[c][v]) + (1 << octave_of[c][v]);
      if (sum >= int'(table_len[c][v]))
         sum -= int'(table_len[c][v]);
      return 11'(sum);
   endfunction

   // Apply one item to copy c; for the live copy, queue the results it causes.
   function automatic void play_item(int c, osc_item_type it);
      osc_result_type r;
      int             rel;
      int             slot;
      logic [15:0]    addr;
      bit             acked;
      r = '0;
      r.kind = KIND_ACK;
      r.status = ST_OK;
      r.last = 1'b1;
      acked = 1'b1;
      case (it.opcode)
         OP_TICK: begin
            acked = 1'b0;
            for (int v = 0; v < VOICES; v++) begin
               r.kind = KIND_SAMPLE;
               r.voice_index = 3'(v);
               r.last = (v == VOICES - 1);
               if (voice_live[c][v]) begin
                  phase_acc[c][v] = stepped_phase(c, v);
                  addr = table_base[c][v] + 16'(phase_acc[c][v]);
                  r.level = wave_mem[c][addr][15:4];
               end else begin
                  r.level = idle_raw[c][15:4];
               end
               if (c == LIVE)
                  due_results.push_back(r);
            end
         end
         OP_NOTE_ON: begin
            r.voice_index = it.voice;
            if (it.midi_note < LOWEST_NOTE) begin
               r.status = ST_LOW;
            end else begin
               rel = int'(it.midi_note) - int'(LOWEST_NOTE);
               if (rel / NOTES_PER_OCTAVE > TOP_OCTAVE) begin
                  r.status = ST_HIGH;
               end else if (it.voice < VOICES) begin
                  slot = active_wave(c) * 12 + rel % NOTES_PER_OCTAVE;
                  phase_acc[c][it.voice] = '0;
                  octave_of[c][it.voice] = 3'(rel / NOTES_PER_OCTAVE);
                  table_base[c][it.voice] = desc_mem[c][slot].base;
                  table_len[c][it.voice] = desc_mem[c][slot].length;
                  voice_live[c][it.voice] = 1'b1;
               end
            end
         end
         OP_VOICE_OFF: begin
            r.voice_index = it.voice;
            if (it.voice < VOICES)
               voice_live[c][it.voice] = 1'b0;
         end
         OP_SAMPLE_WR: begin
            wave_mem[c][it.address] = it.sample_data;
         end
         OP_DESC_WR: begin
            if (it.desc_waveform < WAVES && it.desc_pitch_class < 12) begin
               slot = it.desc_waveform * 12 + it.desc_pitch_class;
               desc_mem[c][slot].base = it.address;
               desc_mem[c][slot].length = (it.desc_length > TABLE_MAX) ?
                                          12'(TABLE_MAX) : it.desc_length;
            end
         end
         default: begin
            // unused opcodes: no result, no state change
            acked = 1'b0;
         end
      endcase
      if (acked && c == LIVE)
         due_results.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------

   function automatic osc_item_type random_fields();
      osc_item_type it;
      it.opcode = 3'($urandom);
      it.voice = 3'($urandom);
      it.midi_note = 7'($urandom);
      it.address = 16'($urandom);
      it.sample_data = 16'($urandom);
      it.desc_waveform = 2'($urandom);
      it.desc_pitch_class = 4'($urandom);
      it.desc_length = 12'($urandom);
      return it;
   endfunction

   function automatic osc_item_type build(logic [2:0] op, logic [2:0] vc, logic [6:0] note,
                                          logic [15:0] addr, logic [15:0] data,
                                          logic [1:0] wf, logic [3:0] pc,
                                          logic [11:0] len);
      osc_item_type it;
      it.opcode = op;
      it.voice = vc;
      it.midi_note = note;
      it.address = addr;
      it.sample_data = data;
      it.desc_waveform = wf;
      it.desc_pitch_class = pc;
      it.desc_length = len;
      return it;
   endfunction

   // Cluster most bases low or just below the top so tables overlap and the
   // wrap of base + phase past the top of memory gets exercised.
   function automatic logic [15:0] pick_base();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 16'($urandom_range(0, 255));
      else if (r < 75)
         return 16'($urandom_range(65280, 65535));
      return 16'($urandom);
   endfunction

   function automatic logic [11:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 12'($urandom_range(128, 200));
      else if (r < 80)
         return 12'(TABLE_MAX);
      else if (r < 88)
         return 12'($urandom_range(TABLE_MAX + 1, 4095));
      else if (r < 94)
         return 12'd0;
      return 12'($urandom_range(1, 127));
   endfunction

   function automatic void enqueue(osc_item_type it);
      queued_items.push_back(it);
      play_item(PLAN, it);
      if (it.opcode == OP_SAMPLE_WR)
         mem_loaded[it.address] = 1'b1;
      if (it.opcode == OP_DESC_WR && it.desc_waveform < WAVES && it.desc_pitch_class < 12)
         desc_loaded[it.desc_waveform * 12 + it.desc_pitch_class] = 1'b1;
      if (it.opcode <= OP_DESC_WR)
         items_made++;
   endfunction

   // Queue an item, preceded by whatever loads keep it from reading
   // a sample word or descriptor that was never written.
   function automatic void offer(osc_item_type it);
      osc_item_type fill;
      logic [15:0]  addr;
      int           rel;
      int           slot;
      if (it.opcode == OP_TICK) begin
         for (int v = 0; v < VOICES; v++) begin
            if (voice_live[PLAN][v]) begin
               addr = table_base[PLAN][v] + 16'(stepped_phase(PLAN, v));
               if (!mem_loaded[addr]) begin
                  fill = random_fields();
                  fill.opcode = OP_SAMPLE_WR;
                  fill.address = addr;
                  enqueue(fill);
               end
            end
         end
      end else if (it.opcode == OP_NOTE_ON && it.midi_note >= LOWEST_NOTE &&
                   it.voice < VOICES) begin
         rel = int'(it.midi_note) - int'(LOWEST_NOTE);
         if (rel / NOTES_PER_OCTAVE <= TOP_OCTAVE) begin
            slot = active_wave(PLAN) * 12 + rel % NOTES_PER_OCTAVE;
            if (!desc_loaded[slot]) begin
               fill = random_fields();
               fill.opcode = OP_DESC_WR;
               fill.desc_waveform = 2'(active_wave(PLAN));
               fill.desc_pitch_class = 4'(rel % NOTES_PER_OCTAVE);
               fill.address = pick_base();
               fill.desc_length = pick_length();
               enqueue(fill);
            end
         end
      end
      enqueue(it);
   endfunction

   function automatic void make_random(int target);
      int           start;
      int           r;
      osc_item_type it;
      start = items_made;
      while (items_made - start < target) begin
         it = random_fields();
         r = $urandom_range(0, 99);
         if (r < 40) begin
            // bursts of ticks let phases run up to and past the wrap
            it.opcode = OP_TICK;
            repeat ($urandom_range(1, 4))
               offer(it);
         end else begin
            if (r < 62) begin
               it.opcode = OP_NOTE_ON;
               it.voice = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) :
                                                       3'($urandom_range(0, 5));
               if ($urandom_range(0, 7) != 0)
                  it.midi_note = 7'(LOWEST_NOTE + 12 * $urandom_range(0, 7) +
                                    $urandom_range(0, 11));
            end else if (r < 70) begin
               it.opcode = OP_VOICE_OFF;
            end else if (r < 80) begin
               it.opcode = OP_SAMPLE_WR;
               if ($urandom_range(0, 1) == 0)
                  it.address = pick_base();
            end else if (r < 94) begin
               it.opcode = OP_DESC_WR;
               if ($urandom_range(0, 9) != 0)
                  it.desc_pitch_class = 4'($urandom_range(0, 11));
               it.address = pick_base();
               it.desc_length = pick_length();
            end else begin
               // noise: opcodes the block drops without a result
               it.opcode = 3'($urandom_range(OP_DESC_WR + 1, 7));
            end
            offer(it);
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offer queued items, hold each until its transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         // the item on the bus moved this edge: advance the live state
         if (req_bus.valid)
            play_item(LIVE, on_bus);
         if (queued_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            on_bus = queued_items.pop_front();
            req_bus.opcode <= on_bus.opcode;
            req_bus.voice <= on_bus.voice;
            req_bus.midi_note <= on_bus.midi_note;
            req_bus.address <= on_bus.address;
            req_bus.sample_data <= on_bus.sample_data;
            req_bus.desc_waveform <= on_bus.desc_waveform;
            req_bus.desc_pitch_class <= on_bus.desc_pitch_class;
            req_bus.desc_length <= on_bus.desc_length;
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver ready: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         // long enough for the output stage to fill and back up the input
         hold_left <= 400;
         hold_done <= 1'b1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: match each result transfer against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatch_count++;
      // cap the log; the count still covers every mismatch
      if (mismatch_count <= 100)
         $display("MISMATCH %s: got %0h want %0h", what, got, want);
   endtask

   always @(posedge clock) begin
      osc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_results.size() == 0) begin
            report_mismatch("result with nothing expected", 16'(rsp_bus.voice_index), '0);
         end else begin
            want = due_results.pop_front();
            if (rsp_bus.kind !== want.kind)
               report_mismatch("kind", 16'(rsp_bus.kind), 16'(want.kind));
            if (rsp_bus.voice_index !== want.voice_index)
               report_mismatch("voice_index", 16'(rsp_bus.voice_index),
                               16'(want.voice_index));
            if (rsp_bus.level !== want.level)
               report_mismatch("level", 16'(rsp_bus.level), 16'(want.level));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 16'(rsp_bus.status), 16'(want.status));
            if (rsp_bus.last !== want.last)
               report_mismatch("last", 16'(rsp_bus.last), 16'(want.last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------------

   // Wait until every queued item has moved and every result has come back,
   // then give the block time to finish anything that produces no result.
   task automatic drain();
      do
         @(posedge clock);
      while (queued_items.size() != 0 || req_bus.valid || due_results.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   // Register write over the config channel; both state copies take it once
   // the transfer happens, as the block is idle at this point.
   task automatic write_reg(logic [7:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do
         @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
      for (int c = 0; c < 2; c++) begin
         if (idx == CSR_WAVEFORM_SELECT)
            sel_wave[c] = val[1:0];
         else if (idx == CSR_IDLE_LEVEL)
            idle_raw[c] = val;
      end
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      osc_item_type tick;
      // hold every input at a known value before the first edge
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_TICK;
      req_bus.voice = '0;
      req_bus.midi_note = '0;
      req_bus.address = '0;
      req_bus.sample_data = '0;
      req_bus.desc_waveform = '0;
      req_bus.desc_pitch_class = '0;
      req_bus.desc_length = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_WAVEFORM_SELECT;
      csr_bus.data = '0;
      send_idle_pct = 19;
      recv_idle_pct = 86;
      hold_req = 1'b0;
      hold_done = 1'b0;
      items_made = 0;
      mismatch_count = 0;
      for (int c = 0; c < 2; c++) begin
         sel_wave[c] = '0;
         idle_raw[c] = 16'd32768;
         for (int v = 0; v < VOICES; v++) begin
            phase_acc[c][v] = '0;
            octave_of[c][v] = '0;
            table_base[c][v] = '0;
            table_len[c][v] = '0;
            voice_live[c][v] = 1'b0;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset configuration. Every voice idle first.
      tick = build(OP_TICK, 3'd0, 7'd0, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0);
      offer(tick);
      for (int op = OP_DESC_WR + 1; op < 8; op++)
         offer(build(3'(op), 3'd7, 7'd127, 16'hFFFF, 16'hFFFF, 2'd3, 4'd15, 12'hFFF));
      // rejected notes, two of them aimed at voices that do not exist
      offer(build(OP_NOTE_ON, 3'd0, 7'd0, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      offer(build(OP_NOTE_ON, 3'd7, 7'd23, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      offer(build(OP_NOTE_ON, 3'd1, 7'd127, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      offer(build(OP_NOTE_ON, 3'd6, 7'd120, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      // tables: 128 long, over-long (clamped) at the top of memory,
      // zero length, shorter than the step, and two that must be dropped
      offer(build(OP_DESC_WR, 3'd0, 7'd0, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd128));
      offer(build(OP_DESC_WR, 3'd0, 7'd0, 16'hFFFF, 16'h0000, 2'd0, 4'd11, 12'hFFF));
      offer(build(OP_DESC_WR, 3'd0, 7'd0, 16'd1000, 16'h0000, 2'd0, 4'd5, 12'd0));
      offer(build(OP_DESC_WR, 3'd0, 7'd0, 16'd2000, 16'h0000, 2'd0, 4'd7, 12'd3));
      offer(build(OP_DESC_WR, 3'd5, 7'd0, 16'h1234, 16'h0000, 2'd3, 4'd15, 12'd200));
      offer(build(OP_DESC_WR, 3'd0, 7'd0, 16'h4321, 16'h0000, 2'd2, 4'd12, 12'd200));
      offer(build(OP_SAMPLE_WR, 3'd0, 7'd0, 16'h0000, 16'hFFFF, 2'd0, 4'd0, 12'd0));
      offer(build(OP_SAMPLE_WR, 3'd0, 7'd0, 16'hFFFF, 16'h0000, 2'd0, 4'd0, 12'd0));
      // lowest note, highest note, zero-length and short tables, bad voices
      offer(build(OP_NOTE_ON, 3'd0, 7'd24, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      offer(build(OP_NOTE_ON, 3'd5, 7'd119, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      offer(build(OP_NOTE_ON, 3'd1, 7'd29, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      offer(build(OP_NOTE_ON, 3'd2, 7'd103, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      offer(build(OP_NOTE_ON, 3'd6, 7'd60, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      repeat (3) offer(tick);
      offer(build(OP_VOICE_OFF, 3'd0, 7'd0, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      offer(build(OP_VOICE_OFF, 3'd7, 7'd0, 16'h0000, 16'h0000, 2'd0, 4'd0, 12'd0));
      offer(tick);
      drain();

      // Random part 1: last waveform set, highest idle level.
      write_reg(CSR_WAVEFORM_SELECT, 16'd3);
      write_reg(CSR_IDLE_LEVEL, 16'hFFFF);
      make_random(100);
      drain();

      // Random part 2: swap the idle rates, idle level at zero.
      send_idle_pct <= 86;
      recv_idle_pct <= 19;
      write_reg(CSR_WAVEFORM_SELECT, 16'd1);
      write_reg(CSR_IDLE_LEVEL, 16'h0000);
      make_random(100);
      drain();

      // Random part 3: full rate both ways, with one long receiver hold-off.
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      write_reg(CSR_WAVEFORM_SELECT, 16'd2);
      write_reg(CSR_IDLE_LEVEL, 16'(16'h1234 ^ $urandom_range(0, 255)));
      hold_req <= 1'b1;
      make_random(100);
      drain();

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/mvwo_pkg.sv
sv/mvwo_if.sv
sv/mvwo_sample_mem.sv
sv/mvwo_desc_mem.sv
sv/mvwo_voice_bank.sv
sv/multi_voice_wavetable_oscillator_core.sv
sim/tb.sv
